// ===== hw/rtl/tpsf_pkg.sv =====
package tpsf_pkg;

  // Number format of positions, differences, lengths and forces
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 31;
  localparam int SUM_W     = 2 * DATA_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING_CONSTANT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH     = 1'b1;

  localparam logic [CFG_W-1:0] SPRING_CONSTANT_RST = CFG_W'(65536);
  localparam logic [CFG_W-1:0] REST_LENGTH_RST     = CFG_W'(65536);

  typedef struct packed {
    logic signed [DATA_W-1:0] self_x;
    logic signed [DATA_W-1:0] self_y;
    logic signed [DATA_W-1:0] self_z;
    logic signed [DATA_W-1:0] partner_x;
    logic signed [DATA_W-1:0] partner_y;
    logic signed [DATA_W-1:0] partner_z;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic                     saturated;
  } out_t;

  // Carried alongside the square root pipeline
  typedef struct packed {
    logic [2:0][DATA_W-1:0] d;
    logic                   sat;
  } root_side_t;

  // Carried alongside the divider pipeline
  typedef struct packed {
    logic [2:0] neg;
    logic       sat;
    logic       len_zero;
  } quot_side_t;

endpackage

// ===== hw/rtl/two_particle_spring_force.sv =====
// Spring force between two particles (Hooke's law in 3-D, signed Q16.16).
// Input: in_data carries the positions of the particle and of its partner;
// it is taken at a rising edge with start high (busy stays low, so a new
// pair can be taken every cycle). Output: out_data holds the force on the
// particle and a saturation flag for exactly one cycle, marked by out_valid;
// the receiver must take it then and cannot stall the block.
// Throughput is one pair per cycle. The pipeline runs: clipped differences,
// squares, sum of squares, the bit-per-stage square root (DATA_W stages),
// E1, E2, E3, N, the bit-per-stage divider (DATA_W stages, three lanes)
// and the output register.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (spring constant, rest length); write only while no pair is in flight.
// Reset: synchronous, active low; drops every pair in flight and restores
// spring constant and rest length to 1.0.
module two_particle_spring_force (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  tpsf_pkg::in_t                     in_data,
  output logic                              out_valid,
  output tpsf_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [tpsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpsf_pkg::CFG_W-1:0]        cfg_data
);

  localparam int DW      = tpsf_pkg::DATA_W;
  localparam int FB      = tpsf_pkg::FRAC_BITS;
  localparam int CW      = tpsf_pkg::CFG_W;
  localparam int SW      = tpsf_pkg::SUM_W;
  localparam int PW      = CW + DW;
  localparam int LATENCY = 2 * DW + 8;
  localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
    logic [DW-1:0] n;
    n = ~v + 1'b1;
    return v[DW-1] ? n : v;
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  logic [CW-1:0] spring_k_r;
  logic [CW-1:0] rest_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_k_r <= tpsf_pkg::SPRING_CONSTANT_RST;
      rest_len_r <= tpsf_pkg::REST_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpsf_pkg::CFG_SPRING_CONSTANT: spring_k_r <= cfg_data;
        tpsf_pkg::CFG_REST_LENGTH:     rest_len_r <= cfg_data;
        default:                       ;
      endcase
    end
  end

  // Stage 0: clipped differences
  logic [DW-1:0]      pos_self [3];
  logic [DW-1:0]      pos_part [3];
  logic [2:0][DW-1:0] d0_nxt;
  logic               sat0_nxt;
  logic               v0_r;
  logic [2:0][DW-1:0] d0_r;
  logic               sat0_r;

  assign pos_self[0] = in_data.self_x;
  assign pos_self[1] = in_data.self_y;
  assign pos_self[2] = in_data.self_z;
  assign pos_part[0] = in_data.partner_x;
  assign pos_part[1] = in_data.partner_y;
  assign pos_part[2] = in_data.partner_z;

  always_comb begin
    logic [DW:0] diff;
    sat0_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff = {pos_self[i][DW-1], pos_self[i]} - {pos_part[i][DW-1], pos_part[i]};
      if (diff[DW] != diff[DW-1]) begin
        d0_nxt[i] = diff[DW] ? NEG_MIN : POS_MAX;
        sat0_nxt  = 1'b1;
      end else begin
        d0_nxt[i] = diff[DW-1:0];
      end
    end
  end

  // Stage 1: squares
  logic [2:0][SW-1:0] sq1_nxt;
  logic               v1_r;
  logic [2:0][SW-1:0] sq1_r;
  logic [2:0][DW-1:0] d1_r;
  logic               sat1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq1_nxt[i] = SW'(mag_of(d0_r[i])) * SW'(mag_of(d0_r[i]));
    end
  end

  // Stage 2: sum of squares
  logic [SW-1:0]      sum2_nxt;
  logic               v2_r;
  logic [SW-1:0]      sum2_r;
  logic [2:0][DW-1:0] d2_r;
  logic               sat2_r;

  assign sum2_nxt = sq1_r[0] + sq1_r[1] + sq1_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    d0_r   <= d0_nxt;
    sat0_r <= sat0_nxt;
    sq1_r  <= sq1_nxt;
    d1_r   <= d0_r;
    sat1_r <= sat0_r;
    sum2_r <= sum2_nxt;
    d2_r   <= d1_r;
    sat2_r <= sat1_r;
  end

  // Length
  tpsf_pkg::root_side_t root_side_in;
  tpsf_pkg::root_side_t root_side_out;
  logic                 root_vld;
  logic [DW-1:0]        len_root;

  assign root_side_in.d   = d2_r;
  assign root_side_in.sat = sat2_r;

  tpsf_sqrt u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (v2_r),
    .in_radicand (sum2_r),
    .in_side     (root_side_in),
    .out_vld     (root_vld),
    .out_root    (len_root),
    .out_side    (root_side_out)
  );

  // E1: extension L - rest, sign and magnitude
  logic [DW:0]        ext;
  logic [DW:0]        ext_neg;
  logic               e1_v_r;
  logic [DW-1:0]      ext_mag_e1_r;
  logic               mneg_e1_r;
  logic [DW-1:0]      len_e1_r;
  logic [2:0][DW-1:0] d_e1_r;
  logic               sat_e1_r;

  assign ext     = (DW+1)'(len_root) - (DW+1)'(rest_len_r);
  assign ext_neg = ~ext + 1'b1;

  // E2: k * |extension|
  logic [PW-1:0]      prod_e2_nxt;
  logic               e2_v_r;
  logic [PW-1:0]      prod_e2_r;
  logic               mneg_e2_r;
  logic [DW-1:0]      len_e2_r;
  logic [2:0][DW-1:0] d_e2_r;
  logic               sat_e2_r;

  assign prod_e2_nxt = PW'(spring_k_r) * PW'(ext_mag_e1_r);

  // E3: scale and clip the magnitude
  logic [PW-FB-1:0]   scaled;
  logic [DW-1:0]      mag_lim;
  logic               mag_clip;
  logic               e3_v_r;
  logic [DW-1:0]      mmag_e3_r;
  logic               mneg_e3_r;
  logic [DW-1:0]      len_e3_r;
  logic [2:0][DW-1:0] d_e3_r;
  logic               sat_e3_r;

  assign scaled   = prod_e2_r[PW-1:FB];
  assign mag_lim  = mneg_e2_r ? NEG_MIN : POS_MAX;
  assign mag_clip = scaled > (PW-FB)'(mag_lim);

  // N: numerators |m| * |d_i| and force signs
  logic [2:0][SW-1:0] num_nxt;
  logic [2:0]         neg_nxt;
  logic               n_v_r;
  logic [2:0][SW-1:0] num_r;
  logic [DW-1:0]      len_n_r;
  tpsf_pkg::quot_side_t quot_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = SW'(mmag_e3_r) * SW'(mag_of(d_e3_r[i]));
      neg_nxt[i] = (mneg_e3_r == d_e3_r[i][DW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
      n_v_r  <= 1'b0;
    end else begin
      e1_v_r <= root_vld;
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
      n_v_r  <= e3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    ext_mag_e1_r <= ext[DW] ? ext_neg[DW-1:0] : ext[DW-1:0];
    mneg_e1_r    <= ext[DW];
    len_e1_r     <= len_root;
    d_e1_r       <= root_side_out.d;
    sat_e1_r     <= root_side_out.sat;

    prod_e2_r    <= prod_e2_nxt;
    mneg_e2_r    <= mneg_e1_r;
    len_e2_r     <= len_e1_r;
    d_e2_r       <= d_e1_r;
    sat_e2_r     <= sat_e1_r;

    mmag_e3_r    <= mag_clip ? mag_lim : scaled[DW-1:0];
    mneg_e3_r    <= mneg_e2_r;
    len_e3_r     <= len_e2_r;
    d_e3_r       <= d_e2_r;
    sat_e3_r     <= sat_e2_r || mag_clip;

    num_r                <= num_nxt;
    len_n_r              <= len_e3_r;
    quot_side_r.neg      <= neg_nxt;
    quot_side_r.sat      <= sat_e3_r;
    quot_side_r.len_zero <= (len_e3_r == '0);
  end

  // Force components |m| * |d_i| / L
  logic                 div_vld;
  logic [2:0][DW-1:0]   quot;
  tpsf_pkg::quot_side_t div_side;

  tpsf_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (n_v_r),
    .in_dividend (num_r),
    .in_divisor  (len_n_r),
    .in_side     (quot_side_r),
    .out_vld     (div_vld),
    .out_quot    (quot),
    .out_side    (div_side)
  );

  // Final: sign, clip and register the result
  logic [2:0][DW-1:0] force_nxt;
  logic               sat_nxt;
  logic               out_valid_r;
  tpsf_pkg::out_t     out_r;

  always_comb begin
    logic [DW-1:0] q;
    logic          neg;
    sat_nxt = div_side.sat;
    for (int i = 0; i < 3; i++) begin
      q   = div_side.len_zero ? '0 : quot[i];
      neg = div_side.neg[i] && (q != '0);
      if (!neg && q > POS_MAX) begin
        q       = POS_MAX;
        sat_nxt = 1'b1;
      end
      force_nxt[i] = neg ? (~q + 1'b1) : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r.force_x   <= force_nxt[0];
    out_r.force_y   <= force_nxt[1];
    out_r.force_z   <= force_nxt[2];
    out_r.saturated <= sat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("transfer did not produce a result on time");

  a_zero_len_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    (div_vld && div_side.len_zero) |=>
      (out_r.force_x == '0 && out_r.force_y == '0 && out_r.force_z == '0))
    else $error("coincident particles gave nonzero force");

  a_zero_len_only_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    (e1_v_r && len_e1_r == '0) |->
      (d_e1_r[0] == '0 && d_e1_r[1] == '0 && d_e1_r[2] == '0))
    else $error("zero length with nonzero difference");
`endif

endmodule

// ===== hw/rtl/tpsf_sqrt.sv =====
module tpsf_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic [tpsf_pkg::SUM_W-1:0]        in_radicand,
  input  tpsf_pkg::root_side_t              in_side,
  output logic                              out_vld,
  output logic [tpsf_pkg::DATA_W-1:0]       out_root,
  output tpsf_pkg::root_side_t              out_side
);

  localparam int DW = tpsf_pkg::DATA_W;
  localparam int RW = tpsf_pkg::SUM_W;

  logic [DW-1:0]        vld_r;
  logic [DW-1:0]        root_r [DW];
  logic [RW-1:0]        rem_r  [DW];
  tpsf_pkg::root_side_t side_r [DW];

  // One root bit per stage, most significant first
  for (genvar s = 0; s < DW; s++) begin : g_stage
    localparam int B = DW - 1 - s;
    logic                 stg_vld;
    logic [DW-1:0]        stg_root;
    logic [RW-1:0]        stg_rem;
    tpsf_pkg::root_side_t stg_side;
    logic [RW:0]          trial;
    logic                 take;

    if (s == 0) begin : g_first
      assign stg_vld  = in_vld;
      assign stg_root = '0;
      assign stg_rem  = in_radicand;
      assign stg_side = in_side;
    end else begin : g_next
      assign stg_vld  = vld_r[s-1];
      assign stg_root = root_r[s-1];
      assign stg_rem  = rem_r[s-1];
      assign stg_side = side_r[s-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = ((RW+1)'(stg_root) << (B + 1)) | ((RW+1)'(1) << (2 * B));
    assign take  = {1'b0, stg_rem} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= stg_vld;
      end
    end

    always_ff @(posedge clk) begin
      root_r[s] <= take ? (stg_root | (DW'(1) << B)) : stg_root;
      rem_r[s]  <= take ? RW'({1'b0, stg_rem} - trial) : stg_rem;
      side_r[s] <= stg_side;
    end
  end

  assign out_vld  = vld_r[DW-1];
  assign out_root = root_r[DW-1];
  assign out_side = side_r[DW-1];

endmodule

// ===== hw/rtl/tpsf_div.sv =====
module tpsf_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  input  logic [2:0][tpsf_pkg::SUM_W-1:0]       in_dividend,
  input  logic [tpsf_pkg::DATA_W-1:0]           in_divisor,
  input  tpsf_pkg::quot_side_t                  in_side,
  output logic                                  out_vld,
  output logic [2:0][tpsf_pkg::DATA_W-1:0]      out_quot,
  output tpsf_pkg::quot_side_t                  out_side
);

  localparam int DW = tpsf_pkg::DATA_W;

  logic [DW-1:0]           vld_r;
  logic [2:0][DW-1:0]      rem_r  [DW];
  logic [2:0][DW-1:0]      lo_r   [DW];
  logic [DW-1:0]           div_r  [DW];
  tpsf_pkg::quot_side_t    side_r [DW];

  // One quotient bit per stage on each lane; quotient bits shift into lo
  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic                 stg_vld;
    logic [2:0][DW-1:0]   stg_rem;
    logic [2:0][DW-1:0]   stg_lo;
    logic [DW-1:0]        stg_div;
    tpsf_pkg::quot_side_t stg_side;
    logic [2:0][DW-1:0]   rem_nxt;
    logic [2:0][DW-1:0]   lo_nxt;

    if (s == 0) begin : g_first
      assign stg_vld = in_vld;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign stg_rem[l] = in_dividend[l][2*DW-1:DW];
        assign stg_lo[l]  = in_dividend[l][DW-1:0];
      end
      assign stg_div  = in_divisor;
      assign stg_side = in_side;
    end else begin : g_next
      assign stg_vld  = vld_r[s-1];
      assign stg_rem  = rem_r[s-1];
      assign stg_lo   = lo_r[s-1];
      assign stg_div  = div_r[s-1];
      assign stg_side = side_r[s-1];
    end

    always_comb begin
      logic [DW:0] sh;
      logic        take;
      for (int l = 0; l < 3; l++) begin
        sh         = {stg_rem[l], stg_lo[l][DW-1]};
        take       = sh >= {1'b0, stg_div};
        rem_nxt[l] = take ? DW'(sh - {1'b0, stg_div}) : sh[DW-1:0];
        lo_nxt[l]  = {stg_lo[l][DW-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= stg_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      lo_r[s]   <= lo_nxt;
      div_r[s]  <= stg_div;
      side_r[s] <= stg_side;
    end
  end

  assign out_vld  = vld_r[DW-1];
  assign out_quot = lo_r[DW-1];
  assign out_side = side_r[DW-1];

endmodule

// ===== sim/two_particle_spring_force_tb.sv =====
`timescale 1ns / 100ps

module two_particle_spring_force_tb;

  localparam int FLUSH_CYCLES = 2 * tpsf_pkg::DATA_W + 16;
  localparam int STALL_LIMIT  = 5000;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  tpsf_pkg::in_t                  in_data;
  logic                           out_valid;
  tpsf_pkg::out_t                 out_data;
  logic                           cfg_we;
  logic [tpsf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tpsf_pkg::CFG_W-1:0]     cfg_data;

  // Testbench copies of the spring registers
  logic [tpsf_pkg::CFG_W-1:0] stiffness;
  logic [tpsf_pkg::CFG_W-1:0] rest_len;

  tpsf_pkg::in_t  pair_q[$];
  tpsf_pkg::out_t force_q[$];
  int             send_idle_pct;
  int             errors;
  int             stall_cnt;

  two_particle_spring_force i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected spring force for one pair under the current register values
  function automatic tpsf_pkg::out_t spring_force(tpsf_pkg::in_t p);
    longint         self_pos[3];
    longint         part_pos[3];
    longint         diff[3];
    logic [63:0]    dmag[3];
    logic [65:0]    sum_sq;
    logic [33:0]    len;
    logic [33:0]    trial;
    logic [67:0]    trial_sq;
    longint         ext;
    logic [34:0]    ext_mag;
    logic [65:0]    prod;
    logic [49:0]    mag_full;
    logic [32:0]    lim;
    logic [63:0]    m_mag;
    logic [63:0]    quot;
    logic [63:0]    res;
    logic           m_neg;
    logic           neg;
    tpsf_pkg::out_t r;
    self_pos = '{longint'(p.self_x), longint'(p.self_y), longint'(p.self_z)};
    part_pos = '{longint'(p.partner_x), longint'(p.partner_y), longint'(p.partner_z)};
    r = '0;
    sum_sq = '0;
    // difference with clipping, then exact sum of squares
    for (int i = 0; i < 3; i++) begin
      diff[i] = self_pos[i] - part_pos[i];
      if (diff[i] > 64'sd2147483647) begin
        diff[i] = 64'sd2147483647;
        r.saturated = 1'b1;
      end
      if (diff[i] < -64'sd2147483648) begin
        diff[i] = -64'sd2147483648;
        r.saturated = 1'b1;
      end
      dmag[i] = (diff[i] < 0) ? 64'(-diff[i]) : 64'(diff[i]);
      sum_sq = sum_sq + 66'(dmag[i]) * 66'(dmag[i]);
    end
    // floor square root, bit by bit
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = len | (34'd1 << b);
      trial_sq = 68'(trial) * 68'(trial);
      if (trial_sq <= 68'(sum_sq)) len = trial;
    end
    // signed extension times stiffness
    ext = longint'(len) - longint'(rest_len);
    m_neg = ext < 0;
    ext_mag = m_neg ? 35'(-ext) : 35'(ext);
    prod = 66'(stiffness) * 66'(ext_mag);
    mag_full = prod[65:tpsf_pkg::FRAC_BITS];
    lim = m_neg ? 33'h1_0000_0000 >> 1 : 33'h0_7FFF_FFFF;
    if (mag_full > 50'(lim)) begin
      mag_full = 50'(lim);
      r.saturated = 1'b1;
    end
    m_mag = 64'(mag_full);
    // force_i = -m * d_i / L, truncated toward zero
    for (int i = 0; i < 3; i++) begin
      quot = (len != 0) ? (m_mag * dmag[i]) / 64'(len) : 64'd0;
      neg = (m_neg == (diff[i] < 0)) && (quot != 0);
      if (!neg && quot > 64'h7FFF_FFFF) begin
        quot = 64'h7FFF_FFFF;
        r.saturated = 1'b1;
      end
      res = neg ? -quot : quot;
      case (i)
        0: r.force_x = res[tpsf_pkg::DATA_W-1:0];
        1: r.force_y = res[tpsf_pkg::DATA_W-1:0];
        default: r.force_z = res[tpsf_pkg::DATA_W-1:0];
      endcase
    end
    return r;
  endfunction

  // Driver: predict on each transfer, then offer the next pair
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) force_q.push_back(spring_force(in_data));
      if (!start || !busy) begin
        if (pair_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          start   <= 1'b1;
          in_data <= pair_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    tpsf_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (force_q.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        want = force_q.pop_front();
        if (out_data.force_x !== want.force_x) begin
          $error("force_x: expected %h, got %h", want.force_x, out_data.force_x);
          errors++;
        end
        if (out_data.force_y !== want.force_y) begin
          $error("force_y: expected %h, got %h", want.force_y, out_data.force_y);
          errors++;
        end
        if (out_data.force_z !== want.force_z) begin
          $error("force_z: expected %h, got %h", want.force_z, out_data.force_z);
          errors++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [tpsf_pkg::CFG_IDX_W-1:0] idx,
                           logic [tpsf_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == tpsf_pkg::CFG_SPRING_CONSTANT) stiffness <= val;
    else rest_len <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued pair is sent and every result is back
  task automatic drain();
    while (pair_q.size() > 0 || start || force_q.size() > 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] coord(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * 65536 * 16)) - 65536 * 16);
      2: return 32'($signed($urandom_range(2 * 65536 * 512)) - 65536 * 512);
      default: return 32'($signed($urandom_range(2 * 256)) - 256);
    endcase
  endfunction

  task automatic add_pair(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                          logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    tpsf_pkg::in_t p;
    p = '{sx, sy, sz, px, py, pz};
    pair_q.push_back(p);
  endtask

  task automatic add_random(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(3);
      if ($urandom_range(19) == 0) begin
        // coincident particles
        add_pair(coord(0), coord(0), coord(0), 0, 0, 0);
        pair_q[$].partner_x = pair_q[$].self_x;
        pair_q[$].partner_y = pair_q[$].self_y;
        pair_q[$].partner_z = pair_q[$].self_z;
      end else begin
        add_pair(coord(kind), coord(kind), coord(kind),
                 coord(kind), coord(kind), coord(kind));
      end
    end
  endtask

  initial begin
    logic [31:0] mx;
    logic [31:0] mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = tpsf_pkg::CFG_SPRING_CONSTANT;
    cfg_data      = '0;
    stiffness     = tpsf_pkg::SPRING_CONSTANT_RST;
    rest_len      = tpsf_pkg::REST_LENGTH_RST;
    send_idle_pct = 16;
    errors        = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs under reset values
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(32'h0001_0000, 0, 0, 0, 0, 0);
    add_pair(32'h0002_0000, 0, 0, 0, 0, 0);
    add_pair(0, 32'h0000_8000, 0, 0, 0, 0);
    add_pair(0, 0, 32'hFFFE_0000, 0, 0, 0);
    add_pair(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0);
    add_pair(mx, mx, mx, mn, mn, mn);
    add_pair(mn, mn, mn, mx, mx, mx);
    add_pair(mx, 0, 0, mn, 0, 0);
    add_pair(mx, mx, mx, mx, mx, mx);
    add_pair(mn, mx, 0, 0, 0, 0);
    add_pair(1, 0, 0, 0, 0, 0);
    add_pair(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0, 0);
    add_random(200);
    drain();

    // Large stiffness: magnitude clipping
    write_reg(tpsf_pkg::CFG_SPRING_CONSTANT, 31'h7FFF_FFFF);
    add_pair(mx, mx, mx, mn, mn, mn);
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(32'h0000_0100, 0, 0, 0, 0, 0);
    add_random(300);
    drain();

    // Zero stiffness and zero rest length
    send_idle_pct = 87;
    write_reg(tpsf_pkg::CFG_SPRING_CONSTANT, 31'd0);
    write_reg(tpsf_pkg::CFG_REST_LENGTH, 31'd0);
    add_random(150);
    drain();

    // Max rest length, mid stiffness
    write_reg(tpsf_pkg::CFG_SPRING_CONSTANT, 31'h0003_0000);
    write_reg(tpsf_pkg::CFG_REST_LENGTH, 31'h7FFF_FFFF);
    add_random(250);
    drain();

    // Random settings, no idling
    send_idle_pct = 0;
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(tpsf_pkg::CFG_SPRING_CONSTANT, 31'($urandom_range(0, 65536 * 64)));
      write_reg(tpsf_pkg::CFG_REST_LENGTH, 31'($urandom()));
      add_random(300);
      drain();
    end

    // Back to reset values
    write_reg(tpsf_pkg::CFG_SPRING_CONSTANT, tpsf_pkg::SPRING_CONSTANT_RST);
    write_reg(tpsf_pkg::CFG_REST_LENGTH, tpsf_pkg::REST_LENGTH_RST);
    add_random(100);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
